FILE: hdl/yuvtsl_pkg.sv
`default_nettype none
package yuvtsl_pkg;

  localparam int DEF_COLOR_SLOTS   = 7;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int MAX_CORDIC_STAGES = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS0    = 3'd1;

  // 255 * sqrt(1.8) / cordic gain, Q20
  localparam int          SAT_MUL_W = 28;
  localparam logic [27:0] SAT_MUL   = 28'd217844205;
  localparam int          SAT_SHIFT = 20;

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

  // round a constant given in units of 1e-4 to the fixed-point scale
  function automatic longint qk(input longint k, input int frac);
    qk = (k * (longint'(1) <<< frac) + 5000) / 10000;
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] turn_angle(input int i);
    case (i)
      0:       turn_angle = 32'h20000000;
      1:       turn_angle = 32'h12E4051E;
      2:       turn_angle = 32'h09FB385B;
      3:       turn_angle = 32'h051111D4;
      4:       turn_angle = 32'h028B0D43;
      5:       turn_angle = 32'h0145D7E1;
      6:       turn_angle = 32'h00A2F61E;
      7:       turn_angle = 32'h00517C55;
      8:       turn_angle = 32'h0028BE53;
      9:       turn_angle = 32'h00145F2F;
      10:      turn_angle = 32'h000A2F98;
      11:      turn_angle = 32'h000517CC;
      12:      turn_angle = 32'h00028BE6;
      13:      turn_angle = 32'h000145F3;
      14:      turn_angle = 32'h0000A2FA;
      15:      turn_angle = 32'h0000517D;
      16:      turn_angle = 32'h000028BE;
      17:      turn_angle = 32'h0000145F;
      18:      turn_angle = 32'h00000A30;
      19:      turn_angle = 32'h00000518;
      20:      turn_angle = 32'h0000028C;
      21:      turn_angle = 32'h00000146;
      22:      turn_angle = 32'h000000A3;
      23:      turn_angle = 32'h00000051;
      default: turn_angle = 32'h00000000;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: hdl/yuvtsl_cordic.sv
`default_nettype none
module yuvtsl_cordic import yuvtsl_pkg::*; #(
  parameter int CW     = DEF_FRAC_BITS + 12,
  parameter int STAGES = DEF_CORDIC_STAGES,
  parameter int SBW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pipe_ctl_t            ctl,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic [31:0]          z_in,
  input  wire logic [SBW-1:0]       side_in,
  output logic                      valid_out,
  output logic signed [CW-1:0]      x_out,
  output logic [31:0]               z_out,
  output logic [SBW-1:0]            side_out
);

  logic                 v_r    [STAGES];
  logic signed [CW-1:0] x_r    [STAGES];
  logic signed [CW-1:0] y_r    [STAGES];
  logic [31:0]          z_r    [STAGES];
  logic [SBW-1:0]       side_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                 vp;
    logic signed [CW-1:0] xp, yp, x_nxt, y_nxt;
    logic [31:0]          zp, z_nxt;
    logic [SBW-1:0]       sp;

    if (i == 0) begin : g_first
      assign vp = ctl.valid;
      assign xp = x_in;
      assign yp = y_in;
      assign zp = z_in;
      assign sp = side_in;
    end else begin : g_next
      assign vp = v_r[i-1];
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign sp = side_r[i-1];
    end

    // rotate toward the x axis
    always_comb begin
      if (!yp[CW-1]) begin
        x_nxt = xp + (yp >>> i);
        y_nxt = yp - (xp >>> i);
        z_nxt = zp + turn_angle(i);
      end else begin
        x_nxt = xp - (yp >>> i);
        y_nxt = yp + (xp >>> i);
        z_nxt = zp - turn_angle(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (ctl.advance) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= sp;
      end
    end
  end

  assign valid_out = v_r[STAGES-1];
  assign x_out     = x_r[STAGES-1];
  assign z_out     = z_r[STAGES-1];
  assign side_out  = side_r[STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/yuvtsl_satdiv.sv
`default_nettype none
module yuvtsl_satdiv import yuvtsl_pkg::*; #(
  parameter int NUMW = DEF_FRAC_BITS + 19,
  parameter int DENW = DEF_FRAC_BITS + 12,
  parameter int SBW  = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pipe_ctl_t       ctl,
  input  wire logic [NUMW-1:0] num_in,
  input  wire logic [DENW-1:0] den_in,
  input  wire logic [SBW-1:0]  side_in,
  output logic                 valid_out,
  output logic                 ovf_out,
  output logic [7:0]           quot_out,
  output logic [SBW-1:0]       side_out
);

  localparam int RW    = DENW + 9;
  localparam int STEPS = 9;

  logic            v_r    [STEPS];
  logic            ovf_r  [STEPS];
  logic [RW-1:0]   rem_r  [STEPS];
  logic [DENW-1:0] den_r  [STEPS];
  logic [7:0]      q_r    [STEPS];
  logic [SBW-1:0]  side_r [STEPS];

  // first step flags quotients above 255, then one quotient bit per step
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic            vp, ovfp, ovf_nxt;
    logic [RW-1:0]   remp, rem_nxt, dsh;
    logic [DENW-1:0] denp;
    logic [7:0]      qp, q_nxt;
    logic [SBW-1:0]  sp;

    if (s == 0) begin : g_first
      assign vp   = ctl.valid;
      assign ovfp = 1'b0;
      assign remp = RW'(num_in);
      assign denp = den_in;
      assign qp   = 8'd0;
      assign sp   = side_in;
      assign dsh  = RW'(den_in) << 8;
      always_comb begin
        ovf_nxt = (remp >= dsh);
        rem_nxt = remp;
        q_nxt   = qp;
      end
    end else begin : g_next
      assign vp   = v_r[s-1];
      assign ovfp = ovf_r[s-1];
      assign remp = rem_r[s-1];
      assign denp = den_r[s-1];
      assign qp   = q_r[s-1];
      assign sp   = side_r[s-1];
      assign dsh  = RW'(denp) << (8 - s);
      always_comb begin
        ovf_nxt = ovfp;
        rem_nxt = remp;
        q_nxt   = qp;
        if (remp >= dsh) begin
          rem_nxt      = remp - dsh;
          q_nxt[8 - s] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (ctl.advance) begin
        v_r[s] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        ovf_r[s]  <= ovf_nxt;
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= denp;
        q_r[s]    <= q_nxt;
        side_r[s] <= sp;
      end
    end
  end

  assign valid_out = v_r[STEPS-1];
  assign ovf_out   = ovf_r[STEPS-1];
  assign quot_out  = q_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule
`default_nettype wire

FILE: hdl/yuv_tsl_color_classifier_core.sv
`default_nettype none
// channel  | handshake            | payload
// input    | in_valid / in_ready  | in_luma, in_chroma_u, in_chroma_v
// result   | out_valid/out_ready  | out_tint, out_saturation, out_matched, out_color_index
// config   | cfg_we               | cfg_index, cfg_data
//
// One pixel per clock. The pipeline stages in order are the chroma
// products, pre-rotation, one CORDIC stage per iteration, gain multiply, nine
// divider steps for saturation, and the slot test into the output register.
// Reset (rst_n low, synchronous) clears all valid bits and configuration.
// The whole pipeline holds while the output register is full and not taken.
module yuv_tsl_color_classifier_core import yuvtsl_pkg::*; #(
  parameter int COLOR_SLOTS   = DEF_COLOR_SLOTS,
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_luma,
  input  wire logic [7:0]            in_chroma_u,
  input  wire logic [7:0]            in_chroma_v,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_tint,
  output logic [7:0]                 out_saturation,
  output logic                       out_matched,
  output logic [2:0]                 out_color_index,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = FRAC_BITS + 12;
  localparam int NS   = (CORDIC_STAGES < MAX_CORDIC_STAGES) ? CORDIC_STAGES
                                                            : MAX_CORDIC_STAGES;
  localparam int PW   = CW - 1 + SAT_MUL_W;
  localparam int NUMW = PW - SAT_SHIFT;
  localparam int CSBW = CW + 11;
  localparam int DSBW = 18;

  localparam logic signed [CW-1:0] Q_Y  = CW'(qk(43403, FRAC_BITS));
  localparam logic signed [CW-1:0] Q_RU = CW'(qk(6697, FRAC_BITS));
  localparam logic signed [CW-1:0] Q_RV = CW'(qk(16959, FRAC_BITS));
  localparam logic signed [CW-1:0] Q_GU = CW'(qk(11680, FRAC_BITS));
  localparam logic signed [CW-1:0] Q_GV = CW'(qk(13626, FRAC_BITS));

  logic adv;

  // configuration
  logic [2:0]            num_colors_r;
  logic [CFG_DATA_W-1:0] bounds_r [COLOR_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_colors_r <= 3'd0;
      for (int k = 0; k < COLOR_SLOTS; k++) begin
        bounds_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_COLORS) begin
        num_colors_r <= cfg_data[2:0];
      end
      for (int k = 0; k < COLOR_SLOTS; k++) begin
        if (cfg_index == CFG_BOUNDS0 + CFG_IDX_W'(k)) begin
          bounds_r[k] <= cfg_data;
        end
      end
    end
  end

  // stage A: chroma products
  logic signed [8:0]    du9, dv9, lum9;
  logic signed [CW-1:0] du_w, dv_w, lum_w;
  logic signed [CW-1:0] cons_nxt, nr_nxt, ng_nxt;
  logic signed [CW-1:0] cons_r, nr_r, ng_r;
  logic [7:0]           luma_a_r;
  logic                 va_r;

  assign du9   = $signed({1'b0, in_chroma_u}) - 9'sd128;
  assign dv9   = $signed({1'b0, in_chroma_v}) - 9'sd128;
  assign lum9  = $signed({1'b0, in_luma});
  assign du_w  = CW'(du9);
  assign dv_w  = CW'(dv9);
  assign lum_w = CW'(lum9);

  assign cons_nxt = Q_Y * lum_w + (((du_w <<< 1) + dv_w) <<< FRAC_BITS);
  assign nr_nxt   = Q_RV * dv_w - Q_RU * du_w;
  assign ng_nxt   = -(Q_GU * du_w) - Q_GV * dv_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cons_r   <= cons_nxt;
      nr_r     <= nr_nxt;
      ng_r     <= ng_nxt;
      luma_a_r <= in_luma;
    end
  end

  // stage B: fold the sign of cons and the left half plane
  logic signed [CW-1:0] xs, ys, x0_nxt, y0_nxt, abscons_nxt;
  logic signed [CW-1:0] x0_r, y0_r;
  logic [31:0]          z0_nxt, z0_r;
  logic [CSBW-1:0]      side_b_r;
  logic                 vb_r;

  always_comb begin
    xs          = cons_r[CW-1] ? -ng_r : ng_r;
    ys          = cons_r[CW-1] ? -nr_r : nr_r;
    x0_nxt      = xs[CW-1] ? -xs : xs;
    y0_nxt      = xs[CW-1] ? -ys : ys;
    z0_nxt      = xs[CW-1] ? 32'h8000_0000 : 32'h0;
    abscons_nxt = cons_r[CW-1] ? -cons_r : cons_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r     <= x0_nxt;
      y0_r     <= y0_nxt;
      z0_r     <= z0_nxt;
      side_b_r <= {luma_a_r, (cons_r == '0), (nr_r == '0) && (ng_r == '0),
                   (ng_r == '0), abscons_nxt};
    end
  end

  // CORDIC
  pipe_ctl_t            cordic_ctl;
  logic                 vc;
  logic signed [CW-1:0] xc;
  logic [31:0]          zc;
  logic [CSBW-1:0]      side_c;

  assign cordic_ctl = '{advance: adv, valid: vb_r};

  yuvtsl_cordic #(
    .CW     (CW),
    .STAGES (NS),
    .SBW    (CSBW)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cordic_ctl),
    .x_in      (x0_r),
    .y_in      (y0_r),
    .z_in      (z0_r),
    .side_in   (side_b_r),
    .valid_out (vc),
    .x_out     (xc),
    .z_out     (zc),
    .side_out  (side_c)
  );

  // stage T: tint scaling and saturation numerator
  logic [7:0]    luma_c;
  logic          cons_zero_c, both_zero_c, ng_zero_c;
  logic [CW-1:0] abscons_c;
  logic [CW-2:0] mag;
  logic [31:0]   zq;
  logic [39:0]   tint_prod;
  logic [7:0]    tint_nxt;

  assign {luma_c, cons_zero_c, both_zero_c, ng_zero_c, abscons_c} = side_c;
  assign mag       = xc[CW-1] ? '0 : xc[CW-2:0];
  assign zq        = zc + 32'h4000_0000;
  assign tint_prod = {zq, 8'h00} - {8'h00, zq};
  assign tint_nxt  = (cons_zero_c || ng_zero_c) ? 8'd0 : tint_prod[39:32];

  logic [PW-1:0]   prod_r;
  logic [CW-1:0]   abscons_t_r;
  logic [DSBW-1:0] side_t_r;
  logic            vt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (adv) begin
      vt_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= PW'(mag) * PW'(SAT_MUL);
      abscons_t_r <= abscons_c;
      side_t_r    <= {luma_c, tint_nxt, cons_zero_c, both_zero_c};
    end
  end

  // saturation quotient
  pipe_ctl_t       div_ctl;
  logic            vd, ovf_d;
  logic [7:0]      quot_d;
  logic [DSBW-1:0] side_d;

  assign div_ctl = '{advance: adv, valid: vt_r};

  yuvtsl_satdiv #(
    .NUMW (NUMW),
    .DENW (CW),
    .SBW  (DSBW)
  ) u_satdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .num_in    (prod_r[PW-1:SAT_SHIFT]),
    .den_in    (abscons_t_r),
    .side_in   (side_t_r),
    .valid_out (vd),
    .ovf_out   (ovf_d),
    .quot_out  (quot_d),
    .side_out  (side_d)
  );

  // slot test
  logic [7:0] luma_d, tint_d, sat_d;
  logic       cons_zero_d, both_zero_d;
  logic       hit;
  logic [2:0] hit_idx;

  assign {luma_d, tint_d, cons_zero_d, both_zero_d} = side_d;

  always_comb begin
    if (cons_zero_d) begin
      sat_d = both_zero_d ? 8'd0 : 8'd255;
    end else begin
      sat_d = ovf_d ? 8'd255 : quot_d;
    end
  end

  always_comb begin
    logic [7:0] t_lo, t_hi, s_lo, s_hi, l_lo, l_hi;
    logic       t_ok;
    hit     = 1'b0;
    hit_idx = 3'd0;
    // scan from the top so the lowest matching slot wins
    for (int k = COLOR_SLOTS - 1; k >= 0; k--) begin
      t_lo = bounds_r[k][7:0];
      t_hi = bounds_r[k][15:8];
      s_lo = bounds_r[k][23:16];
      s_hi = bounds_r[k][31:24];
      l_lo = bounds_r[k][39:32];
      l_hi = bounds_r[k][47:40];
      if (t_lo < t_hi) begin
        t_ok = (t_lo <= tint_d) && (tint_d <= t_hi);
      end else begin
        t_ok = !((t_hi <= tint_d) && (tint_d <= t_lo));
      end
      if ((3'(k) < num_colors_r) && t_ok &&
          (s_lo <= sat_d) && (sat_d <= s_hi) &&
          (l_lo <= luma_d) && (luma_d <= l_hi)) begin
        hit     = 1'b1;
        hit_idx = 3'(k);
      end
    end
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_tint_r, out_sat_r;
  logic       out_matched_r;
  logic [2:0] out_idx_r;

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tint_r    <= tint_d;
      out_sat_r     <= sat_d;
      out_matched_r <= hit;
      out_idx_r     <= hit_idx;
    end
  end

  assign in_ready        = adv;
  assign out_valid       = out_valid_r;
  assign out_tint        = out_tint_r;
  assign out_saturation  = out_sat_r;
  assign out_matched     = out_matched_r;
  assign out_color_index = out_idx_r;

endmodule
`default_nettype wire
